>>> rtl/word_frequency_counter_unit_defines.svh
// Assertion macros for the word frequency counter unit.
// Included by the top-level RTL file, which carries the concurrent checks; no other dependencies.
`ifndef WORD_FREQUENCY_COUNTER_UNIT_DEFINES_SVH
`define WORD_FREQUENCY_COUNTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define WFCU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define WFCU_CHECK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WFCU_ASSERT(lbl, clk, rstn, prop, msg)
`define WFCU_CHECK(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/wfc_pkg.sv
// Shared types, constants and helper functions for the word frequency counter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package wfc_pkg;

    // Table and token sizing
    localparam int TABLE_SLOTS     = 1024;
    localparam int MAX_TOKEN_CHARS = 255;
    localparam int SLOT_W          = $clog2(TABLE_SLOTS);
    localparam int DIST_W          = SLOT_W + 1;
    localparam int IDX_W           = $clog2(MAX_TOKEN_CHARS);
    localparam int FILL_W          = $clog2(MAX_TOKEN_CHARS + 1);
    localparam int KEY_AW          = SLOT_W + IDX_W;
    localparam int CNT_W           = 32;
    localparam int CSUM_W          = 48;

    // Insert refused once entries_used + 1 reaches this (0.7 load)
    localparam int LOAD_LIMIT      = (TABLE_SLOTS * 7 + 9) / 10;

    localparam int HASH_SEED       = 5381;
    localparam logic [SLOT_W-1:0] HASH_SEED_LOW = SLOT_W'(HASH_SEED % TABLE_SLOTS);

    // Input function codes
    localparam logic [1:0] FUNC_TEXT   = 2'd0;
    localparam logic [1:0] FUNC_EOF    = 2'd1;
    localparam logic [1:0] FUNC_REPORT = 2'd2;

    // Result kinds
    localparam logic KIND_TOKEN  = 1'b0;
    localparam logic KIND_TOTALS = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic [FILL_W-1:0] token_length;
        logic [CNT_W-1:0]  word_count;
        logic              is_new;
        logic              table_full;
        logic [CNT_W-1:0]  tokens_total;
        logic [DIST_W-1:0] distinct_total;
        logic [CSUM_W-1:0] length_checksum;
    } t_out_word;

    // Table access request from the sequencer
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [IDX_W-1:0]  idx;
        logic              len_we;
        logic [FILL_W-1:0] len_wdata;
        logic              cnt_we;
        logic [CNT_W-1:0]  cnt_wdata;
        logic              key_we;
        logic [7:0]        key_wdata;
    } t_tbl_cmd;

    // Registered table read data
    typedef struct packed {
        logic [FILL_W-1:0] len;
        logic [CNT_W-1:0]  cnt;
        logic [7:0]        key;
    } t_tbl_rd;

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        fold_lower = ((c >= 8'h41) && (c <= 8'h5A)) ? (c | 8'h20) : c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/wfc_token.sv
// Token accumulator: character buffer, fill count and running slot hash.
// Depends on wfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wfc_token (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [7:0]                   i_char,
    input  wire logic                         i_clear,
    input  wire logic [wfc_pkg::IDX_W-1:0]    i_rd_idx,
    output logic [7:0]                        o_rd_char,
    output logic [wfc_pkg::FILL_W-1:0]        o_fill,
    output logic [wfc_pkg::SLOT_W-1:0]        o_hash
);

    logic [7:0]                  r_chars [wfc_pkg::MAX_TOKEN_CHARS];
    logic [wfc_pkg::FILL_W-1:0]  r_fill;
    logic [wfc_pkg::SLOT_W-1:0]  r_hash;
    logic [wfc_pkg::SLOT_W-1:0]  n_hash;
    logic                        w_room;

    assign w_room = (r_fill < wfc_pkg::FILL_W'(wfc_pkg::MAX_TOKEN_CHARS));
    // h*33 ^ c, kept modulo the table size
    assign n_hash = wfc_pkg::SLOT_W'((r_hash << 5) + r_hash) ^ wfc_pkg::SLOT_W'(i_char);

    // Append a kept letter; drop letters past the limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_hash <= wfc_pkg::HASH_SEED_LOW;
        end else if (i_clear) begin
            r_fill <= '0;
            r_hash <= wfc_pkg::HASH_SEED_LOW;
        end else if (i_push && w_room) begin
            r_fill <= r_fill + 1'b1;
            r_hash <= n_hash;
        end
    end

    // Character store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_push && w_room && !i_clear) begin
            r_chars[r_fill[wfc_pkg::IDX_W-1:0]] <= i_char;
        end
        o_rd_char <= r_chars[i_rd_idx];
    end

    assign o_fill = r_fill;
    assign o_hash = r_hash;

endmodule
`default_nettype wire

>>> rtl/wfc_table.sv
// Hash table storage: key lengths, key characters and counts, registered reads.
// Depends on wfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wfc_table (
    input  wire logic              i_clk,
    input  wire wfc_pkg::t_tbl_cmd i_cmd,
    output wfc_pkg::t_tbl_rd       o_rd
);

    logic [wfc_pkg::FILL_W-1:0] r_len  [wfc_pkg::TABLE_SLOTS];
    logic [wfc_pkg::CNT_W-1:0]  r_cnt  [wfc_pkg::TABLE_SLOTS];
    logic [7:0]                 r_keys [2**wfc_pkg::KEY_AW];
    logic [wfc_pkg::KEY_AW-1:0] w_kaddr;
    logic [wfc_pkg::FILL_W-1:0] r_rd_len;
    logic [wfc_pkg::CNT_W-1:0]  r_rd_cnt;
    logic [7:0]                 r_rd_key;

    assign w_kaddr = {i_cmd.slot, i_cmd.idx};

    // Key length per slot, zero marks an empty slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.len_we) begin
            r_len[i_cmd.slot] <= i_cmd.len_wdata;
        end
        r_rd_len <= r_len[i_cmd.slot];
    end

    // Count per slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_we) begin
            r_cnt[i_cmd.slot] <= i_cmd.cnt_wdata;
        end
        r_rd_cnt <= r_cnt[i_cmd.slot];
    end

    // Key characters, one row per slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_we) begin
            r_keys[w_kaddr] <= i_cmd.key_wdata;
        end
        r_rd_key <= r_keys[w_kaddr];
    end

    assign o_rd = '{len: r_rd_len, cnt: r_rd_cnt, key: r_rd_key};

endmodule
`default_nettype wire

>>> rtl/word_frequency_counter_unit.sv
// Word frequency counter, top level: handshake, probe sequencer and totals.
// Depends on wfc_pkg, wfc_token, wfc_table and the assertion macro header.
//
// Text bytes go in one word at a time; letters are folded to lower case and kept
// (up to 255 per token), and a letter byte leaves the sequencer idle. A separator or
// end-of-file word closes a non-empty token, which is then looked up by linear
// probing in a 1024-slot table through single-port reads with registered data:
// each probed slot is read, then checked; each character of a slot whose key
// length matches is read, then compared; a new key is copied in one character
// at a time, read then written; an insert or update ends the lookup. A totals
// report goes straight to the finish state. A finished result sits in an output
// register, so the next word is taken while it waits. After reset a clearing
// pass over all 1024 slots empties the table; no word is accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "word_frequency_counter_unit_defines.svh"
module word_frequency_counter_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire wfc_pkg::t_in_word  i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output wfc_pkg::t_out_word      o_data
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_PROBE_RD, ST_PROBE_CHK, ST_CMP_RD, ST_CMP_CHK,
        ST_COPY_RD, ST_COPY_WR, ST_INSERT, ST_UPDATE, ST_FINISH
    } t_state;

    t_state                      r_state;
    logic [wfc_pkg::SLOT_W-1:0]  r_slot;
    logic [wfc_pkg::SLOT_W-1:0]  r_probes;
    logic [wfc_pkg::IDX_W-1:0]   r_k;
    logic                        r_kind;
    logic                        r_full;
    logic                        r_is_new;
    logic [wfc_pkg::CNT_W-1:0]   r_cnt;
    logic [wfc_pkg::DIST_W-1:0]  r_used;
    logic [wfc_pkg::CNT_W-1:0]   r_tally;
    logic [wfc_pkg::CSUM_W-1:0]  r_csum;
    logic                        r_ovalid;
    wfc_pkg::t_out_word          r_odata;

    logic [wfc_pkg::CNT_W-1:0]   n_cnt;
    logic [wfc_pkg::CNT_W-1:0]   n_tally;
    logic [wfc_pkg::CSUM_W-1:0]  n_csum;
    logic [wfc_pkg::CSUM_W:0]    w_csum_sum;
    wfc_pkg::t_out_word          n_odata;

    logic                        w_accept;
    logic                        w_letter;
    logic                        w_push;
    logic                        w_close;
    logic                        w_out_free;
    logic                        w_load;
    logic                        w_tok_clear;
    logic                        w_at_limit;
    logic                        w_last_char;
    logic [7:0]                  w_tok_char;
    logic [wfc_pkg::FILL_W-1:0]  w_fill;
    logic [wfc_pkg::SLOT_W-1:0]  w_hash;
    wfc_pkg::t_tbl_cmd           w_cmd;
    wfc_pkg::t_tbl_rd            w_rd;

    // Input decode
    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_letter = wfc_pkg::is_letter(i_data.data_byte);
    assign w_push   = w_accept && (i_data.func == wfc_pkg::FUNC_TEXT) && w_letter;
    assign w_close  = w_accept && (w_fill != '0)
                      && (((i_data.func == wfc_pkg::FUNC_TEXT) && !w_letter)
                          || (i_data.func == wfc_pkg::FUNC_EOF));

    assign w_out_free  = !r_ovalid || i_ready;
    assign w_load      = (r_state == ST_FINISH) && w_out_free;
    assign w_tok_clear = w_load && (r_kind == wfc_pkg::KIND_TOKEN);
    assign w_at_limit  = ((r_used + 1'b1) >= wfc_pkg::DIST_W'(wfc_pkg::LOAD_LIMIT));
    assign w_last_char = (wfc_pkg::FILL_W'(r_k) == wfc_pkg::FILL_W'(w_fill - 1'b1));

    // Saturating updates of count, tally and checksum
    assign n_cnt      = (&w_rd.cnt) ? w_rd.cnt : w_rd.cnt + 1'b1;
    assign n_tally    = (&r_tally) ? r_tally : r_tally + 1'b1;
    assign w_csum_sum = {1'b0, r_csum} + (wfc_pkg::CSUM_W + 1)'(w_fill);
    assign n_csum     = w_csum_sum[wfc_pkg::CSUM_W] ? '1 : w_csum_sum[wfc_pkg::CSUM_W-1:0];

    wfc_token u_token (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_char    (wfc_pkg::fold_lower(i_data.data_byte)),
        .i_clear   (w_tok_clear),
        .i_rd_idx  (r_k),
        .o_rd_char (w_tok_char),
        .o_fill    (w_fill),
        .o_hash    (w_hash)
    );

    // Table requests follow the sequencer state
    always_comb begin
        w_cmd           = '0;
        w_cmd.slot      = r_slot;
        w_cmd.idx       = r_k;
        w_cmd.key_wdata = w_tok_char;
        w_cmd.len_wdata = (r_state == ST_INSERT) ? w_fill : '0;
        w_cmd.cnt_wdata = (r_state == ST_INSERT) ? wfc_pkg::CNT_W'(1) : n_cnt;
        w_cmd.len_we    = (r_state == ST_CLEAR) || (r_state == ST_INSERT);
        w_cmd.cnt_we    = (r_state == ST_INSERT) || (r_state == ST_UPDATE);
        w_cmd.key_we    = (r_state == ST_COPY_WR);
    end

    wfc_table u_table (
        .i_clk (i_clk),
        .i_cmd (w_cmd),
        .o_rd  (w_rd)
    );

    // Assemble the result word
    always_comb begin
        n_odata      = '0;
        n_odata.kind = r_kind;
        if (r_kind == wfc_pkg::KIND_TOTALS) begin
            n_odata.tokens_total    = r_tally;
            n_odata.distinct_total  = r_used;
            n_odata.length_checksum = r_csum;
        end else if (r_full) begin
            n_odata.token_length = w_fill;
            n_odata.table_full   = 1'b1;
        end else begin
            n_odata.slot            = r_slot;
            n_odata.token_length    = w_fill;
            n_odata.word_count      = r_cnt;
            n_odata.is_new          = r_is_new;
            n_odata.tokens_total    = r_tally;
            n_odata.distinct_total  = r_used;
            n_odata.length_checksum = r_csum;
        end
    end

    // Sequencer, totals and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_slot   <= '0;
            r_used   <= '0;
            r_tally  <= '0;
            r_csum   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // load a finished result, or drop the one just taken
            if (w_load) begin
                r_ovalid <= 1'b1;
                r_odata  <= n_odata;
            end else if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_slot <= r_slot + 1'b1;
                    if (&r_slot) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    r_full   <= 1'b0;
                    r_is_new <= 1'b0;
                    if (w_accept && (i_data.func == wfc_pkg::FUNC_REPORT)) begin
                        r_kind  <= wfc_pkg::KIND_TOTALS;
                        r_state <= ST_FINISH;
                    end else if (w_close) begin
                        r_kind   <= wfc_pkg::KIND_TOKEN;
                        r_slot   <= w_hash;
                        r_probes <= '0;
                        r_k      <= '0;
                        r_state  <= ST_PROBE_RD;
                    end
                end
                ST_PROBE_RD: begin
                    r_state <= ST_PROBE_CHK;
                end
                ST_PROBE_CHK: begin
                    r_k <= '0;
                    if (w_rd.len == '0) begin
                        if (w_at_limit) begin
                            r_full  <= 1'b1;
                            r_state <= ST_FINISH;
                        end else begin
                            r_state <= ST_COPY_RD;
                        end
                    end else if (w_rd.len == w_fill) begin
                        r_state <= ST_CMP_RD;
                    end else if (&r_probes) begin
                        r_full  <= 1'b1;
                        r_state <= ST_FINISH;
                    end else begin
                        r_probes <= r_probes + 1'b1;
                        r_slot   <= r_slot + 1'b1;
                        r_state  <= ST_PROBE_RD;
                    end
                end
                ST_CMP_RD: begin
                    r_state <= ST_CMP_CHK;
                end
                ST_CMP_CHK: begin
                    if (w_rd.key != w_tok_char) begin
                        // mismatch: move on to the next slot
                        if (&r_probes) begin
                            r_full  <= 1'b1;
                            r_state <= ST_FINISH;
                        end else begin
                            r_probes <= r_probes + 1'b1;
                            r_slot   <= r_slot + 1'b1;
                            r_state  <= ST_PROBE_RD;
                        end
                    end else if (w_last_char) begin
                        r_state <= ST_UPDATE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_CMP_RD;
                    end
                end
                ST_COPY_RD: begin
                    r_state <= ST_COPY_WR;
                end
                ST_COPY_WR: begin
                    if (w_last_char) begin
                        r_state <= ST_INSERT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_COPY_RD;
                    end
                end
                ST_INSERT: begin
                    r_cnt    <= wfc_pkg::CNT_W'(1);
                    r_is_new <= 1'b1;
                    r_used   <= r_used + 1'b1;
                    r_tally  <= n_tally;
                    r_csum   <= n_csum;
                    r_state  <= ST_FINISH;
                end
                ST_UPDATE: begin
                    r_cnt   <= n_cnt;
                    r_tally <= n_tally;
                    r_csum  <= n_csum;
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    // Checks
    `WFCU_ASSERT(a_load_bound, i_clk, i_rst_n, (r_used < wfc_pkg::DIST_W'(wfc_pkg::LOAD_LIMIT)), "key count passed the load limit")
    `WFCU_ASSERT(a_cmp_index, i_clk, i_rst_n, ((r_state == ST_CMP_CHK) || (r_state == ST_COPY_WR)) |-> (wfc_pkg::FILL_W'(r_k) < w_fill), "character index ran past the token")
    `WFCU_ASSERT(a_clear_quiet, i_clk, i_rst_n, (r_state == ST_CLEAR) |-> (!o_valid && !o_ready), "activity during the clearing pass")
    `WFCU_CHECK(a_reset_clear, i_clk, (!i_rst_n) |=> (r_state == ST_CLEAR), "reset did not start the clearing pass")

endmodule
`default_nettype wire

>>> dv/word_frequency_counter_unit_checker.sv
// Checker for the word frequency counter: watches both channels, predicts each result word
// and compares it field by field. Depends on wfc_pkg only.
`timescale 1ns / 1ps
module word_frequency_counter_unit_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  wfc_pkg::t_in_word  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  wfc_pkg::t_out_word i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import wfc_pkg::*;

    // Predicted table and token state
    logic [7:0]  tok_chars [MAX_TOKEN_CHARS];
    int unsigned tok_fill;
    logic [63:0] tok_hash;
    int unsigned key_len [TABLE_SLOTS];
    logic [7:0]  key_chars [TABLE_SLOTS][MAX_TOKEN_CHARS];
    logic [31:0] key_count [TABLE_SLOTS];
    int unsigned keys_held;
    logic [31:0] tally;
    logic [47:0] csum;

    t_out_word expected_words [$];

    initial o_fail_count = 0;
    assign o_pending = expected_words.size();

    function automatic bit key_equal(int unsigned s);
        if (key_len[s] != tok_fill) return 0;
        for (int k = 0; k < tok_fill; k++)
            if (key_chars[s][k] != tok_chars[k]) return 0;
        return 1;
    endfunction

    // Look up the open token, update the table and queue its result
    task automatic count_word();
        t_out_word r;
        int unsigned s;
        int unsigned probes;
        bit found;
        r = '0;
        found = 0;
        s = 32'(tok_hash % TABLE_SLOTS);
        for (probes = 0; probes < TABLE_SLOTS; probes++) begin
            if (key_len[s] == 0) break;
            if (key_equal(s)) begin
                found = 1;
                break;
            end
            s = (s + 1) % TABLE_SLOTS;
        end
        r.kind = KIND_TOKEN;
        r.token_length = FILL_W'(tok_fill);
        if (!found && ((keys_held + 1) * 10 >= TABLE_SLOTS * 7 || probes >= TABLE_SLOTS)) begin
            r.table_full = 1'b1;
            expected_words.push_back(r);
            return;
        end
        if (!found) begin
            for (int k = 0; k < tok_fill; k++) key_chars[s][k] = tok_chars[k];
            key_len[s] = tok_fill;
            key_count[s] = 1;
            keys_held++;
            r.is_new = 1'b1;
        end else if (key_count[s] != 32'hFFFF_FFFF) begin
            key_count[s]++;
        end
        if (tally != 32'hFFFF_FFFF) tally++;
        csum = (csum > 48'hFFFF_FFFF_FFFF - tok_fill) ? 48'hFFFF_FFFF_FFFF : csum + tok_fill;
        r.slot = SLOT_W'(s);
        r.word_count = key_count[s];
        r.tokens_total = tally;
        r.distinct_total = DIST_W'(keys_held);
        r.length_checksum = csum;
        expected_words.push_back(r);
    endtask

    task automatic close_word();
        if (tok_fill == 0) return;
        count_word();
        tok_fill = 0;
        tok_hash = HASH_SEED;
    endtask

    task automatic predict_word(t_in_word w);
        logic [7:0] c;
        t_out_word r;
        c = w.data_byte;
        case (w.func)
            FUNC_TEXT: begin
                if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
                    if (c <= "Z") c = c + 8'd32;
                    if (tok_fill < MAX_TOKEN_CHARS) begin
                        tok_chars[tok_fill] = c;
                        tok_fill++;
                        tok_hash = ((tok_hash << 5) + tok_hash) ^ 64'(c);
                    end
                end else begin
                    close_word();
                end
            end
            FUNC_EOF: close_word();
            FUNC_REPORT: begin
                r = '0;
                r.kind = KIND_TOTALS;
                r.tokens_total = tally;
                r.distinct_total = DIST_W'(keys_held);
                r.length_checksum = csum;
                expected_words.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Compare one result word against the oldest expectation
    task automatic check_word(t_out_word a);
        t_out_word e;
        if (expected_words.size() == 0) begin
            $error("unexpected result word %p", a);
            o_fail_count++;
            return;
        end
        e = expected_words.pop_front();
        if (a.kind != e.kind) begin
            $error("kind: expected %0d actual %0d", e.kind, a.kind); o_fail_count++;
        end
        if (a.slot != e.slot) begin
            $error("slot: expected %0d actual %0d", e.slot, a.slot); o_fail_count++;
        end
        if (a.token_length != e.token_length) begin
            $error("token_length: expected %0d actual %0d", e.token_length, a.token_length);
            o_fail_count++;
        end
        if (a.word_count != e.word_count) begin
            $error("word_count: expected %0d actual %0d", e.word_count, a.word_count);
            o_fail_count++;
        end
        if (a.is_new != e.is_new) begin
            $error("is_new: expected %0d actual %0d", e.is_new, a.is_new); o_fail_count++;
        end
        if (a.table_full != e.table_full) begin
            $error("table_full: expected %0d actual %0d", e.table_full, a.table_full);
            o_fail_count++;
        end
        if (a.tokens_total != e.tokens_total) begin
            $error("tokens_total: expected %0d actual %0d", e.tokens_total, a.tokens_total);
            o_fail_count++;
        end
        if (a.distinct_total != e.distinct_total) begin
            $error("distinct_total: expected %0d actual %0d", e.distinct_total,
                   a.distinct_total);
            o_fail_count++;
        end
        if (a.length_checksum != e.length_checksum) begin
            $error("length_checksum: expected %0d actual %0d", e.length_checksum,
                   a.length_checksum);
            o_fail_count++;
        end
    endtask

    // Reset the prediction, then track every accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tok_fill = 0;
            tok_hash = HASH_SEED;
            for (int s = 0; s < TABLE_SLOTS; s++) key_len[s] = 0;
            keys_held = 0;
            tally = '0;
            csum = '0;
        end else begin
            if (i_in_valid && i_in_ready) predict_word(i_in_data);
            if (i_out_valid && i_out_ready) check_word(i_out_data);
        end
    end
endmodule

>>> dv/word_frequency_counter_unit_test.sv
// Testbench top for the word frequency counter: clock, reset, text stimulus and verdict.
// Depends on wfc_pkg, the unit and word_frequency_counter_unit_checker.
`timescale 1ns / 1ps
module word_frequency_counter_unit_test;
    import wfc_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_data;
    int        fail_count;
    int        pending;
    int        cycles;
    int        burst_left;
    int        stall_mode;

    localparam int CYCLE_LIMIT = 3_000_000;

    word_frequency_counter_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_data(in_data),
        .o_valid(out_valid), .i_ready(out_ready), .o_data(out_data)
    );

    word_frequency_counter_unit_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Bound the run
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver stall pattern: phases of always-ready, random, and mostly stalled
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Send one word, with bursts and gaps around it
    task automatic send_word(logic [1:0] f, logic [7:0] b);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        in_valid <= 1'b1;
        in_data <= '{func: f, data_byte: b};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        if (burst_left == 0) in_valid <= 1'b0;
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) send_word(FUNC_TEXT, s[k]);
    endtask

    // Random word from a small vocabulary, so repeats are common
    task automatic send_random_token();
        int n;
        int v;
        v = $urandom_range(0, 40);
        n = 1 + v % 6;
        for (int k = 0; k < n; k++)
            send_word(FUNC_TEXT, 8'((($urandom_range(0, 1)) ? "A" : "a") + (v + k * 7) % 26));
    endtask

    initial begin
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        stall_mode = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty closes, report, case folding, boundary letters, func 3
        send_word(FUNC_EOF, 8'h00);
        send_word(FUNC_TEXT, 8'h20);
        send_word(FUNC_REPORT, 8'hFF);
        send_text("AZaz@[`{ ");
        send_text("azAZ");
        send_word(FUNC_EOF, 8'h00);
        send_word(2'd3, 8'h41);
        send_word(FUNC_TEXT, 8'h00);
        send_word(FUNC_TEXT, 8'hFF);
        send_word(FUNC_TEXT, "q");
        send_word(FUNC_REPORT, 8'h00);
        send_word(FUNC_EOF, 8'h00);

        // Pause until the block has delivered everything
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        // Longest token: letters past the limit are skipped
        for (int k = 0; k < 260; k++) send_word(FUNC_TEXT, 8'("a" + k % 26));
        send_word(FUNC_EOF, 8'h55);

        // Random: mostly words and separators, some noise and reports
        for (int k = 0; k < 60; k++) begin
            case ($urandom_range(0, 9))
                0: send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                1: send_word(FUNC_REPORT, 8'($urandom_range(0, 255)));
                2: send_word(FUNC_EOF, 8'($urandom_range(0, 255)));
                default: begin
                    send_random_token();
                    send_word(FUNC_TEXT,
                              ($urandom_range(0, 1)) ? 8'h20 : 8'($urandom_range(0, 64)));
                end
            endcase
        end

        send_text("aqz ");
        send_word(FUNC_REPORT, 8'h00);
        in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (1500) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/wfc_pkg.sv
rtl/wfc_token.sv
rtl/wfc_table.sv
rtl/word_frequency_counter_unit.sv
dv/word_frequency_counter_unit_checker.sv
dv/word_frequency_counter_unit_test.sv
